// ===== rtl/sqvg_pkg.sv =====
// Shared widths, codes, stage records and the quarter-wave sine table of the sprite vertex block.
`default_nettype none

package sqvg_pkg;

   // Field widths
   localparam int COORD_W  = 32;
   localparam int SIZE_W   = 31;
   localparam int ANGLE_W  = 16;
   localparam int TEX_W    = 17;
   localparam int SLOT_W   = 10;
   localparam int CNT_W    = 11;
   localparam int CORNER_W = 2;
   localparam int LIM_W    = 17;

   // Arithmetic widths: sin/cos are signed Q1.16 in [-1, 1]
   localparam int SIN_W  = 18;
   localparam int PROD_W = 50;
   localparam int OFS_W  = PROD_W - 17;
   localparam int SUM_W  = COORD_W + 2;

   // Stream payload widths, padded to whole bytes
   localparam int REQ_TDATA_W = 216;
   localparam int RSP_TDATA_W = 112;

   localparam logic [CNT_W-1:0] BATCH_LIMIT_RST = 11'd1024;

   // Request kinds carried in tuser
   localparam logic REQ_BEGIN = 1'b0;
   localparam logic REQ_ADD   = 1'b1;

   // Corner codes, in emission order
   localparam logic [CORNER_W-1:0] CORNER_BL = 2'd0;
   localparam logic [CORNER_W-1:0] CORNER_TL = 2'd1;
   localparam logic [CORNER_W-1:0] CORNER_TR = 2'd2;
   localparam logic [CORNER_W-1:0] CORNER_BR = 2'd3;

   // Quarter-wave table: entries 0..SINE_TABLE_DEPTH, unsigned Q1.16
   localparam int SINE_TABLE_DEPTH = 256;
   localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH);
   localparam int TAB_AW = IDX_W + 1;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   // Taylor divisors (2n)(2n+1) for n = 1..7
   localparam logic [7:1][7:0] TAYLOR_DIV =
      {8'd210, 8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};

   typedef logic [SINE_TABLE_DEPTH:0][TEX_W-1:0] sine_tab_type;

   function automatic sine_tab_type build_sine();
      sine_tab_type       tab;
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        t;
      logic [63:0]        q;
      logic signed [63:0] sum;
      for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
         x   = (64'(k) * HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
         x2  = (x * x) >> 30;
         t   = x;
         sum = signed'(x);
         for (int n = 1; n <= 7; n++) begin
            t = ((t * x2) >> 30) / 64'(TAYLOR_DIV[n]);
            if (n[0]) begin
               sum = sum - signed'(t);
            end else begin
               sum = sum + signed'(t);
            end
         end
         if (sum < 0) begin
            sum = '0;
         end
         q = (unsigned'(sum) + 64'd8192) >> 14;
         if (q > 64'd65536) begin
            q = 64'd65536;
         end
         tab[k] = TEX_W'(q);
      end
      tab[0]                = '0;
      tab[SINE_TABLE_DEPTH] = TEX_W'(65536);
      return tab;
   endfunction

   localparam sine_tab_type SINE_TAB = build_sine();

   // Input register contents: one accepted sprite (or an overflow marker)
   typedef struct packed {
      logic                     ovf;
      logic [SLOT_W-1:0]        slot;
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
      logic [SIZE_W-1:0]        w;
      logic [SIZE_W-1:0]        h;
      logic signed [SIN_W-1:0]  sin_v;
      logic signed [SIN_W-1:0]  cos_v;
      logic [TEX_W-1:0]         u_left;
      logic [TEX_W-1:0]         u_right;
      logic [TEX_W-1:0]         v_lo;
      logic [TEX_W-1:0]         v_hi;
   } item_type;

   // Product register contents
   typedef struct packed {
      logic                      ovf;
      logic [SLOT_W-1:0]         slot;
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
      logic signed [PROD_W-1:0]  wc;
      logic signed [PROD_W-1:0]  ws;
      logic signed [PROD_W-1:0]  hc;
      logic signed [PROD_W-1:0]  hs;
      logic [TEX_W-1:0]          u_left;
      logic [TEX_W-1:0]          u_right;
      logic [TEX_W-1:0]          v_lo;
      logic [TEX_W-1:0]          v_hi;
   } prod_type;

   // One corner with its rounded offsets, before the center add
   typedef struct packed {
      logic                      ovf;
      logic                      last;
      logic [CORNER_W-1:0]       corner;
      logic [SLOT_W-1:0]         slot;
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
      logic signed [OFS_W-1:0]   ox;
      logic signed [OFS_W-1:0]   oy;
      logic [TEX_W-1:0]          u;
      logic [TEX_W-1:0]          v;
   } corner_type;

   // Finished vertex result
   typedef struct packed {
      logic                      ovf;
      logic                      last;
      logic [CORNER_W-1:0]       corner;
      logic [SLOT_W-1:0]         slot;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [TEX_W-1:0]          u;
      logic [TEX_W-1:0]          v;
   } vertex_type;

endpackage

`default_nettype wire

// ===== rtl/sqvg_sincos.sv =====
// Quarter-wave table lookup giving signed sine and cosine of a binary angle.
`default_nettype none

module sqvg_sincos
   import sqvg_pkg::*;
(
   input  wire logic [ANGLE_W-1:0]     angle,
   output logic signed [SIN_W-1:0]     sin_v,
   output logic signed [SIN_W-1:0]     cos_v
);

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;

   logic [1:0]              quad;
   logic [TAB_AW-1:0]       idx;
   logic signed [SIN_W-1:0] lo;
   logic signed [SIN_W-1:0] hi;

   assign quad = angle[ANGLE_W-1 -: 2];
   assign idx  = {1'b0, angle[ANGLE_W-3 -: IDX_W]};
   assign lo   = signed'({1'b0, SINE_TAB[idx]});
   assign hi   = signed'({1'b0, SINE_TAB[TAB_AW'(SINE_TABLE_DEPTH) - idx]});

   always_comb begin
      if (angle == '0) begin
         // zero angle: unrotated quad
         sin_v = '0;
         cos_v = SIN_W'(65536);
      end else begin
         case (quad)
            QUAD_0: begin
               sin_v = lo;
               cos_v = hi;
            end
            QUAD_1: begin
               sin_v = hi;
               cos_v = -lo;
            end
            QUAD_2: begin
               sin_v = -lo;
               cos_v = -hi;
            end
            default: begin
               sin_v = -hi;
               cos_v = lo;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== rtl/sqvg_rotate.sv =====
// Product stage: multiplies the sprite size by sine and cosine and registers the results.
`default_nettype none

module sqvg_rotate
   import sqvg_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  wire item_type in_item,
   output logic          out_valid,
   input  wire logic     out_take,
   output prod_type      out_prod
);

   logic                      valid_ff;
   logic                      valid_in;
   prod_type                  prod_ff;
   prod_type                  prod_in;
   logic signed [COORD_W-1:0] w_s;
   logic signed [COORD_W-1:0] h_s;

   assign in_ready  = !valid_ff || out_take;
   assign out_valid = valid_ff;
   assign out_prod  = prod_ff;

   assign w_s = signed'({1'b0, in_item.w});
   assign h_s = signed'({1'b0, in_item.h});

   always_comb begin
      prod_in         = prod_ff;
      prod_in.ovf     = in_item.ovf;
      prod_in.slot    = in_item.slot;
      prod_in.cx      = in_item.cx;
      prod_in.cy      = in_item.cy;
      prod_in.wc      = PROD_W'(w_s) * PROD_W'(in_item.cos_v);
      prod_in.ws      = PROD_W'(w_s) * PROD_W'(in_item.sin_v);
      prod_in.hc      = PROD_W'(h_s) * PROD_W'(in_item.cos_v);
      prod_in.hs      = PROD_W'(h_s) * PROD_W'(in_item.sin_v);
      prod_in.u_left  = in_item.u_left;
      prod_in.u_right = in_item.u_right;
      prod_in.v_lo    = in_item.v_lo;
      prod_in.v_hi    = in_item.v_hi;
   end

   always_comb begin
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (out_take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         prod_ff <= prod_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/sqvg_corner.sv =====
// Corner sequencer: walks the four corners, rounds offsets, adds the center with saturation.
`default_nettype none

module sqvg_corner
   import sqvg_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   input  wire prod_type in_prod,
   output logic          in_take,
   output logic          out_valid,
   input  wire logic     out_ready,
   output vertex_type    out_vert
);

   localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(65536);

   logic [CORNER_W-1:0]       cnt_ff;
   logic [CORNER_W-1:0]       cnt_in;
   logic                      cvalid_ff;
   logic                      cvalid_in;
   corner_type                corner_ff;
   corner_type                corner_in;
   logic                      ovalid_ff;
   logic                      ovalid_in;
   vertex_type                vert_ff;
   vertex_type                vert_in;
   logic                      emit;
   logic                      adv_out;
   logic                      sw_neg;
   logic                      sh_neg;
   logic signed [PROD_W-1:0]  sum_x;
   logic signed [PROD_W-1:0]  sum_y;
   logic signed [SUM_W-1:0]   pos_x;
   logic signed [SUM_W-1:0]   pos_y;

   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
      logic signed [COORD_W-1:0] r;
      if (v[SUM_W-1:COORD_W-1] == '0 || v[SUM_W-1:COORD_W-1] == '1) begin
         r = v[COORD_W-1:0];
      end else if (v[SUM_W-1]) begin
         r = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(COORD_W-1){1'b1}}};
      end
      return r;
   endfunction

   assign adv_out = cvalid_ff && (!ovalid_ff || out_ready);
   assign emit    = in_valid && (!cvalid_ff || adv_out);
   assign in_take = emit && (in_prod.ovf || cnt_ff == CORNER_BR);

   // Left corners negate the width term, bottom corners negate the height term
   assign sw_neg = (cnt_ff == CORNER_BL) || (cnt_ff == CORNER_TL);
   assign sh_neg = (cnt_ff == CORNER_BL) || (cnt_ff == CORNER_BR);

   // Rounding bias folded into the sum; the bit select below floors
   assign sum_x = (sw_neg ? -in_prod.wc : in_prod.wc)
                + (sh_neg ? in_prod.hs : -in_prod.hs) + HALF_LSB;
   assign sum_y = (sw_neg ? -in_prod.ws : in_prod.ws)
                + (sh_neg ? -in_prod.hc : in_prod.hc) + HALF_LSB;

   always_comb begin
      corner_in        = corner_ff;
      corner_in.ovf    = in_prod.ovf;
      corner_in.last   = in_prod.ovf || (cnt_ff == CORNER_BR);
      corner_in.corner = cnt_ff;
      corner_in.slot   = in_prod.slot;
      corner_in.cx     = in_prod.cx;
      corner_in.cy     = in_prod.cy;
      corner_in.ox     = sum_x[PROD_W-1:PROD_W-OFS_W];
      corner_in.oy     = sum_y[PROD_W-1:PROD_W-OFS_W];
      corner_in.u      = sw_neg ? in_prod.u_left : in_prod.u_right;
      corner_in.v      = sh_neg ? in_prod.v_hi : in_prod.v_lo;
   end

   assign pos_x = SUM_W'(corner_ff.cx) + SUM_W'(corner_ff.ox);
   assign pos_y = SUM_W'(corner_ff.cy) + SUM_W'(corner_ff.oy);

   always_comb begin
      vert_in.ovf    = corner_ff.ovf;
      vert_in.last   = corner_ff.last;
      vert_in.corner = corner_ff.corner;
      vert_in.slot   = corner_ff.slot;
      vert_in.x      = sat_coord(pos_x);
      vert_in.y      = sat_coord(pos_y);
      vert_in.u      = corner_ff.u;
      vert_in.v      = corner_ff.v;
   end

   always_comb begin
      if (in_take) begin
         cnt_in = CORNER_BL;
      end else if (emit) begin
         cnt_in = cnt_ff + 1'b1;
      end else begin
         cnt_in = cnt_ff;
      end
      if (emit) begin
         cvalid_in = 1'b1;
      end else if (adv_out) begin
         cvalid_in = 1'b0;
      end else begin
         cvalid_in = cvalid_ff;
      end
      if (adv_out) begin
         ovalid_in = 1'b1;
      end else if (out_ready) begin
         ovalid_in = 1'b0;
      end else begin
         ovalid_in = ovalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= CORNER_BL;
         cvalid_ff <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         cvalid_ff <= cvalid_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         corner_ff <= corner_in;
      end
      if (adv_out) begin
         vert_ff <= vert_in;
      end
   end

   assign out_valid = ovalid_ff;
   assign out_vert  = vert_ff;

endmodule

`default_nettype wire

// ===== rtl/sprite_quad_vertex_generator.sv =====
// Top level of the rotated sprite quad vertex generator.
// The first vertex of a sprite reaches rsp through the input, product, corner and output registers.
// Throughput: one vertex per cycle from the shared corner stage unless rsp_tready stalls it;
// a sprite yields four vertices, an overflow one result, and a begin no result.
// Reset (synchronous): empties the pipeline, clears the batch count, sets batch_limit to 1024.
`default_nettype none

module sprite_quad_vertex_generator
   import sqvg_pkg::*;
#(
   parameter int MAX_SPRITES = 1024
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // batch_limit register
   input  wire logic                   csr_we,
   input  wire logic [CNT_W-1:0]       csr_wdata,
   // request stream
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // center_x, center_y, size_w, size_h, rot_angle, flip_x,
   // tex_u_lo, tex_u_hi, tex_v_lo, tex_v_hi (lowest bit up), zero pad
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // req_type
   input  wire logic                   req_tuser,
   // result stream
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // vert_x, vert_y, vert_u, vert_v, corner, slot (lowest bit up), zero pad
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   // overflow
   output logic                        rsp_tuser,
   // last
   output logic                        rsp_tlast
);

   // Request field positions in tdata
   localparam int CX_LSB    = 0;
   localparam int CY_LSB    = CX_LSB + COORD_W;
   localparam int W_LSB     = CY_LSB + COORD_W;
   localparam int H_LSB     = W_LSB + SIZE_W;
   localparam int ANG_LSB   = H_LSB + SIZE_W;
   localparam int FLIP_LSB  = ANG_LSB + ANGLE_W;
   localparam int ULO_LSB   = FLIP_LSB + 1;
   localparam int UHI_LSB   = ULO_LSB + TEX_W;
   localparam int VLO_LSB   = UHI_LSB + TEX_W;
   localparam int VHI_LSB   = VLO_LSB + TEX_W;
   localparam int RSP_USED  = 2 * COORD_W + 2 * TEX_W + CORNER_W + SLOT_W;

   localparam logic [LIM_W-1:0] MAX_LIM = LIM_W'(MAX_SPRITES);

   logic [CNT_W-1:0]        limit_ff;
   logic [CNT_W-1:0]        limit_in;
   logic [CNT_W-1:0]        sprite_cnt_ff;
   logic [CNT_W-1:0]        sprite_cnt_in;
   logic [LIM_W-1:0]        eff_limit;
   logic                    batch_full;
   logic                    req_xfer;
   logic                    is_add;
   logic                    load;
   logic                    valid0_ff;
   logic                    valid0_in;
   item_type                item_ff;
   item_type                item_in;
   logic                    adv0;
   logic                    rot_ready;
   logic                    prod_valid;
   prod_type                prod;
   logic                    prod_take;
   vertex_type              vert;
   logic                    flip;
   logic [TEX_W-1:0]        u_lo;
   logic [TEX_W-1:0]        u_hi;
   logic signed [SIN_W-1:0] sin_v;
   logic signed [SIN_W-1:0] cos_v;

   // ---------------------------------------------------------------
   // Batch limit register and sprite count. The effective limit is
   // the register capped at MAX_SPRITES; a limit of zero rejects all.
   // ---------------------------------------------------------------
   assign limit_in   = csr_we ? csr_wdata : limit_ff;
   assign eff_limit  = (LIM_W'(limit_ff) > MAX_LIM) ? MAX_LIM : LIM_W'(limit_ff);
   assign batch_full = LIM_W'(sprite_cnt_ff) >= eff_limit;

   assign req_xfer = req_tvalid && req_tready;
   assign is_add   = (req_tuser == REQ_ADD);

   always_comb begin
      if (req_xfer && !is_add) begin
         sprite_cnt_in = '0;
      end else if (req_xfer && !batch_full) begin
         sprite_cnt_in = sprite_cnt_ff + 1'b1;
      end else begin
         sprite_cnt_in = sprite_cnt_ff;
      end
   end

   // ---------------------------------------------------------------
   // Input register. A begin transfer only resets the count and never
   // enters the pipeline. A rejected sprite enters as an all-zero item
   // with the overflow flag, which then flows out as one zero result.
   // ---------------------------------------------------------------
   sqvg_sincos u_sincos (
      .angle (req_tdata[ANG_LSB +: ANGLE_W]),
      .sin_v (sin_v),
      .cos_v (cos_v)
   );

   assign flip = req_tdata[FLIP_LSB];
   assign u_lo = req_tdata[ULO_LSB +: TEX_W];
   assign u_hi = req_tdata[UHI_LSB +: TEX_W];

   always_comb begin
      item_in = '0;
      if (batch_full) begin
         item_in.ovf = 1'b1;
      end else begin
         item_in.slot    = sprite_cnt_ff[SLOT_W-1:0];
         item_in.cx      = signed'(req_tdata[CX_LSB +: COORD_W]);
         item_in.cy      = signed'(req_tdata[CY_LSB +: COORD_W]);
         item_in.w       = req_tdata[W_LSB +: SIZE_W];
         item_in.h       = req_tdata[H_LSB +: SIZE_W];
         item_in.sin_v   = sin_v;
         item_in.cos_v   = cos_v;
         // horizontal flip swaps the u bounds
         item_in.u_left  = flip ? u_hi : u_lo;
         item_in.u_right = flip ? u_lo : u_hi;
         item_in.v_lo    = req_tdata[VLO_LSB +: TEX_W];
         item_in.v_hi    = req_tdata[VHI_LSB +: TEX_W];
      end
   end

   // Advance when the product stage takes the item; accept a new one then
   assign adv0       = valid0_ff && rot_ready;
   assign req_tready = !valid0_ff || adv0;
   assign load       = req_xfer && is_add;

   always_comb begin
      if (load) begin
         valid0_in = 1'b1;
      end else if (adv0) begin
         valid0_in = 1'b0;
      end else begin
         valid0_in = valid0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff      <= BATCH_LIMIT_RST;
         sprite_cnt_ff <= '0;
         valid0_ff     <= 1'b0;
      end else begin
         limit_ff      <= limit_in;
         sprite_cnt_ff <= sprite_cnt_in;
         valid0_ff     <= valid0_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
   end

   // ---------------------------------------------------------------
   // Product stage, then the corner sequencer with the output register.
   // The product register holds a sprite for its four corners.
   // ---------------------------------------------------------------
   sqvg_rotate u_rotate (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid0_ff),
      .in_ready  (rot_ready),
      .in_item   (item_ff),
      .out_valid (prod_valid),
      .out_take  (prod_take),
      .out_prod  (prod)
   );

   sqvg_corner u_corner (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prod_valid),
      .in_prod   (prod),
      .in_take   (prod_take),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_vert  (vert)
   );

   // Pack the result: x, y, u, v, corner, slot from bit 0 up
   assign rsp_tdata = {{(RSP_TDATA_W-RSP_USED){1'b0}}, vert.slot, vert.corner,
                       vert.v, vert.u, vert.y, vert.x};
   assign rsp_tuser = vert.ovf;
   assign rsp_tlast = vert.last;

`ifndef SYNTHESIS
   // A rejected sprite gives a single all-zero result that ends the item
   a_ovf_result_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tlast && rsp_tdata == '0))
      else $error("overflow result not zero or not last");

   // A vertex result ends the item exactly on the bottom-right corner
   a_last_on_br : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |->
         (rsp_tlast == (rsp_tdata[2*COORD_W+2*TEX_W +: CORNER_W] == CORNER_BR)))
      else $error("last flag does not match corner");

   // An accepted sprite in a batch with room bumps the count by one
   a_count_step : assert property (@(posedge clock) disable iff (reset)
      (req_xfer && is_add && !batch_full) |=>
         (sprite_cnt_ff == $past(sprite_cnt_ff) + 1'b1))
      else $error("sprite count did not advance");

   // The overflow marker leaves the product stage in one corner step
   a_ovf_single : assert property (@(posedge clock) disable iff (reset)
      (prod_valid && prod.ovf) |-> prod_take || !rsp_tready || rsp_tvalid)
      else $error("overflow item held in product stage");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the rotated sprite quad vertex generator.
`timescale 1ns / 100ps

module testbench
   import sqvg_pkg::*;
();

   // Block configuration and the predictor's own constants
   localparam int SPRITE_CAP = 1024;
   localparam int TABLE_STEPS = 256;
   localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;

   // One request as it travels on req_tdata/req_tuser; cx sits in the lowest bits
   typedef struct packed {
      logic                      kind;
      logic [TEX_W-1:0]          v_hi, v_lo, u_hi, u_lo;
      logic                      flip;
      logic [ANGLE_W-1:0]        angle;
      logic [SIZE_W-1:0]         h, w;
      logic signed [COORD_W-1:0] cy, cx;
   } sprite_req_type;

   // One vertex; laid out so that {tuser, tlast, tdata[109:0]} maps onto it directly
   typedef struct packed {
      logic                      ovf, last;
      logic [SLOT_W-1:0]         slot;
      logic [CORNER_W-1:0]       corner;
      logic [TEX_W-1:0]          v, u;
      logic signed [COORD_W-1:0] y, x;
   } vertex_rec_type;

   // One row of the directed table: a limit write or a request, with optional typed answers
   typedef struct packed {
      logic                      is_cfg;
      logic [CNT_W-1:0]          limit;
      logic                      typed_xy, typed_ovf;
      logic [0:3][COORD_W-1:0]   xs, ys;
      sprite_req_type            req;
   } plan_row_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CNT_W-1:0]       csr_wdata;
   logic                   req_tvalid;
   logic                   req_tready;
   // center_x, center_y, size_w, size_h, rot_angle, flip_x,
   // tex_u_lo, tex_u_hi, tex_v_lo, tex_v_hi (lowest bit up), zero pad
   logic [REQ_TDATA_W-1:0] req_tdata;
   // req_type
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   // vert_x, vert_y, vert_u, vert_v, corner, slot (lowest bit up), zero pad
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   // overflow
   logic                   rsp_tuser;
   // last
   logic                   rsp_tlast;

   // Predictor state: quarter-wave table, batch count and limit register
   logic [TEX_W-1:0] sine_q16 [0:TABLE_STEPS];
   int               batch_count;
   int               limit_reg;

   vertex_rec_type   pending_vertices [$];
   plan_row_type     plan [$];
   int               error_count;
   int               vertices_seen;
   bit               calm;
   bit               req_gaps;

   // Limits walked by the random phases; phase 6 draws its own
   logic [CNT_W-1:0] phase_limit [8] =
      '{11'd2, 11'd1, 11'd0, 11'd7, 11'd2047, 11'd1024, 11'd0, 11'd1024};

   sprite_quad_vertex_generator #(
      .MAX_SPRITES(SPRITE_CAP)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Build the sine table: Taylor series to x^15 in Q30, then round to Q1.16
   function automatic void fill_sine();
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        t;
      logic [63:0]        q;
      logic signed [63:0] sum;
      for (int k = 0; k <= TABLE_STEPS; k++) begin
         x   = (64'(k) * QUARTER_TURN_Q30) / 64'(TABLE_STEPS);
         x2  = (x * x) >> 30;
         t   = x;
         sum = signed'(x);
         for (int n = 1; n <= 7; n++) begin
            t = ((t * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
               sum = sum - signed'(t);
            end else begin
               sum = sum + signed'(t);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         q = (unsigned'(sum) + 64'd8192) >> 14;
         if (q > 64'd65536) begin
            q = 64'd65536;
         end
         sine_q16[k] = q[TEX_W-1:0];
      end
      sine_q16[0]           = '0;
      sine_q16[TABLE_STEPS] = TEX_W'(65536);
   endfunction

   function automatic logic signed [COORD_W-1:0] saturate_coord(input longint v);
      if (v > 64'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end
      if (v < -64'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return v[COORD_W-1:0];
   endfunction

   // Work out the vertices one accepted request yields and advance the batch count
   function automatic int predict_quad(input sprite_req_type q,
                                       output vertex_rec_type [3:0] quad);
      longint           s, c, lo, hi, w, h, sw, sh, dx, dy;
      int               idx;
      int               cap;
      logic [TEX_W-1:0] u_left, u_right;
      quad = '0;
      if (q.kind == REQ_BEGIN) begin
         batch_count = 0;
         return 0;
      end
      cap = (limit_reg > SPRITE_CAP) ? SPRITE_CAP : limit_reg;
      if (batch_count >= cap) begin
         quad[0].ovf  = 1'b1;
         quad[0].last = 1'b1;
         return 1;
      end
      // Angle zero lands on table entries 0 and 256, i.e. sin 0 and cos 1: same as the bypass
      idx = q.angle[13:6];
      lo  = longint'(sine_q16[idx]);
      hi  = longint'(sine_q16[TABLE_STEPS - idx]);
      case (q.angle[15:14])
         2'd0: begin s = lo;  c = hi;  end
         2'd1: begin s = hi;  c = -lo; end
         2'd2: begin s = -lo; c = -hi; end
         default: begin s = -hi; c = lo; end
      endcase
      w       = longint'(q.w);
      h       = longint'(q.h);
      u_left  = q.flip ? q.u_hi : q.u_lo;
      u_right = q.flip ? q.u_lo : q.u_hi;
      for (int k = 0; k < 4; k++) begin
         sw = (k >= 2) ? 1 : -1;
         sh = (k == 1 || k == 2) ? 1 : -1;
         // Divide by 2^17, round to nearest with ties up
         dx = (sw * w * c - sh * h * s + 65536) >>> 17;
         dy = (sw * w * s + sh * h * c + 65536) >>> 17;
         quad[k].x      = saturate_coord(longint'(q.cx) + dx);
         quad[k].y      = saturate_coord(longint'(q.cy) + dy);
         quad[k].u      = (k < 2) ? u_left : u_right;
         quad[k].v      = (k == 0 || k == 3) ? q.v_hi : q.v_lo;
         quad[k].corner = CORNER_W'(k);
         quad[k].slot   = batch_count[SLOT_W-1:0];
         quad[k].last   = (k == 3);
      end
      batch_count++;
      return 4;
   endfunction

   function automatic sprite_req_type sprite(input logic kind,
                                        input logic signed [COORD_W-1:0] cx, cy,
                                        input logic [SIZE_W-1:0] w, h,
                                        input logic [ANGLE_W-1:0] angle,
                                        input logic flip,
                                        input logic [TEX_W-1:0] u_lo, u_hi, v_lo, v_hi);
      sprite_req_type q;
      q.kind = kind;
      q.cx = cx;       q.cy = cy;
      q.w = w;         q.h = h;
      q.angle = angle; q.flip = flip;
      q.u_lo = u_lo;   q.u_hi = u_hi;
      q.v_lo = v_lo;   q.v_hi = v_hi;
      return q;
   endfunction

   function automatic void put(input sprite_req_type q);
      plan_row_type row;
      row     = '0;
      row.req = q;
      plan.push_back(row);
   endfunction

   function automatic void put_xy(input sprite_req_type q,
                                  input logic [0:3][COORD_W-1:0] xs, ys);
      plan_row_type row;
      row          = '0;
      row.req      = q;
      row.typed_xy = 1'b1;
      row.xs       = xs;
      row.ys       = ys;
      plan.push_back(row);
   endfunction

   function automatic void put_ovf(input sprite_req_type q);
      plan_row_type row;
      row           = '0;
      row.req       = q;
      row.typed_ovf = 1'b1;
      plan.push_back(row);
   endfunction

   function automatic void put_limit(input logic [CNT_W-1:0] v);
      plan_row_type row;
      row        = '0;
      row.is_cfg = 1'b1;
      row.limit  = v;
      plan.push_back(row);
   endfunction

   // Random field values, weighted toward the extremes
   function automatic logic signed [COORD_W-1:0] pick_coord();
      case ($urandom_range(0, 7))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return COORD_W'($urandom_range(0, 131071)) - 32'sd65536;
         default: return COORD_W'($urandom);
      endcase
   endfunction

   function automatic logic [SIZE_W-1:0] pick_size();
      case ($urandom_range(0, 7))
         0: return 31'h7FFF_FFFF;
         1: return '0;
         2, 3: return SIZE_W'($urandom_range(0, 32'h4_0000));
         default: return SIZE_W'($urandom);
      endcase
   endfunction

   function automatic logic [TEX_W-1:0] pick_tex();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return TEX_W'(65536);
         2: return TEX_W'($urandom);
         default: return TEX_W'($urandom_range(0, 65536));
      endcase
   endfunction

   function automatic sprite_req_type random_request(input logic kind);
      logic [ANGLE_W-1:0] angle;
      case ($urandom_range(0, 7))
         0: angle = '0;
         1: angle = ANGLE_W'($urandom_range(0, 3) << 14);
         default: angle = ANGLE_W'($urandom);
      endcase
      return sprite(kind, pick_coord(), pick_coord(), pick_size(), pick_size(), angle,
                    1'($urandom), pick_tex(), pick_tex(), pick_tex(), pick_tex());
   endfunction

   // Drop valid; the argument n sets the length of the pause
   task automatic pause(input int n);
      @(negedge clock);
      req_tvalid <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   // Offer one request and hold it until the transfer happens
   task automatic offer(input sprite_req_type q);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= q.kind;
      req_tdata  <= REQ_TDATA_W'({q.v_hi, q.v_lo, q.u_hi, q.u_lo, q.flip, q.angle,
                                  q.h, q.w, q.cy, q.cx});
      do @(posedge clock); while (!req_tready);
   endtask

   // Send one row and queue what it should produce; typed answers override the prediction
   task automatic send_row(input plan_row_type row);
      vertex_rec_type [3:0] quad;
      int                   n;
      if (!calm) begin
         if ($urandom_range(0, 15) == 0) begin
            req_gaps = !req_gaps;
         end
         if (req_gaps && $urandom_range(0, 2) == 0) begin
            pause($urandom_range(1, 7));
         end
      end
      offer(row.req);
      n = predict_quad(row.req, quad);
      if (row.typed_ovf) begin
         n            = 1;
         quad         = '0;
         quad[0].ovf  = 1'b1;
         quad[0].last = 1'b1;
      end
      for (int k = 0; k < n; k++) begin
         if (row.typed_xy) begin
            quad[k].x = row.xs[k];
            quad[k].y = row.ys[k];
         end
         pending_vertices.push_back(quad[k]);
      end
   endtask

   // Write batch_limit once the block has drained; begins leave no result, so
   // keep req_tvalid low past the empty queue before the write
   task automatic write_limit(input logic [CNT_W-1:0] v);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_vertices.size() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we    <= 1'b0;
      limit_reg = v;
   endtask

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // Compare every result transfer against the oldest expected vertex
   always @(posedge clock) begin
      vertex_rec_type got;
      vertex_rec_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser, rsp_tlast, rsp_tdata[109:0]};
         vertices_seen++;
         if (pending_vertices.size() == 0) begin
            $error("unexpected result transfer: x %0d y %0d overflow %0b",
                   got.x, got.y, got.ovf);
            error_count++;
         end else begin
            want = pending_vertices.pop_front();
            check_field("vert_x", longint'(want.x), longint'(got.x));
            check_field("vert_y", longint'(want.y), longint'(got.y));
            check_field("vert_u", want.u, got.u);
            check_field("vert_v", want.v, got.v);
            check_field("corner", want.corner, got.corner);
            check_field("slot", want.slot, got.slot);
            check_field("overflow", want.ovf, got.ovf);
            check_field("last", want.last, got.last);
         end
      end
   end

   // Receiver: random stall bursts in stretches, plus one long hold once traffic is flowing
   // so that the block backs up into req_tready
   initial begin : rsp_side
      int hold;
      bit squeezed;
      bit stalls_on;
      hold       = 0;
      squeezed   = 1'b0;
      stalls_on  = 1'b1;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 39) == 0) begin
            stalls_on = !stalls_on;
         end
         if (!squeezed && vertices_seen >= 150) begin
            squeezed = 1'b1;
            hold     = 400;
         end
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else if (!calm && stalls_on && $urandom_range(0, 4) == 0) begin
            hold = $urandom_range(0, 6);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Stimulus: reset, directed table, random phases, drain and verdict
   initial begin : req_side
      plan_row_type row;
      clock         = 1'b0;
      reset         = 1'b1;
      csr_we        = 1'b0;
      csr_wdata     = '0;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = REQ_BEGIN;
      error_count   = 0;
      vertices_seen = 0;
      calm          = 1'b0;
      req_gaps      = 1'b1;
      batch_count   = 0;
      limit_reg     = 1024;
      fill_sine();

      // Begin with every other field at all ones: must be ignored
      put(sprite(REQ_BEGIN, -32'sd1, -32'sd1, '1, '1, '1, 1'b1, '1, '1, '1, '1));
      // Angle zero, 2.0 x 2.0 at the origin: corners at plus or minus 1.0
      put_xy(sprite(REQ_ADD, 32'sd0, 32'sd0, 31'h2_0000, 31'h2_0000, 16'h0000, 1'b0,
                    17'd0, 17'd65536, 17'd0, 17'd65536),
             {-32'sd65536, -32'sd65536, 32'sd65536, 32'sd65536},
             {-32'sd65536, 32'sd65536, 32'sd65536, -32'sd65536});
      // Same with flip and texture bounds above 1.0
      put_xy(sprite(REQ_ADD, 32'sd0, 32'sd0, 31'h2_0000, 31'h2_0000, 16'h0000, 1'b1,
                    17'h00100, 17'h1FFFF, 17'h1FFFF, 17'd0),
             {-32'sd65536, -32'sd65536, 32'sd65536, 32'sd65536},
             {-32'sd65536, 32'sd65536, 32'sd65536, -32'sd65536});
      // Largest sizes at opposite corners of the plane: sums saturate
      put_xy(sprite(REQ_ADD, 32'sh7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                    16'h0000, 1'b0, 17'd65536, 17'd0, 17'd65536, 17'd0),
             {32'sd1073741824, 32'sd1073741824, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF},
             {32'sh8000_0000, -32'sd1073741824, -32'sd1073741824, 32'sh8000_0000});
      put_xy(sprite(REQ_ADD, 32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                    16'h0000, 1'b1, 17'h1FFFF, 17'h0AAAA, 17'h15555, 17'd1),
             {32'sh8000_0000, 32'sh8000_0000, -32'sd1073741824, -32'sd1073741824},
             {32'sd1073741824, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sd1073741824});
      // Zero size: every corner sits on the center whatever the angle
      put_xy(sprite(REQ_ADD, 32'sh1234_5678, -32'sd5, 31'd0, 31'd0, 16'h1234, 1'b0,
                    17'd3, 17'd4, 17'd5, 17'd6),
             {32'sh1234_5678, 32'sh1234_5678, 32'sh1234_5678, 32'sh1234_5678},
             {-32'sd5, -32'sd5, -32'sd5, -32'sd5});
      // Quadrant boundaries and table edges
      put(sprite(REQ_ADD, 32'sd0, 32'sd0, 31'h10_0000, 31'h8_0000, 16'h4000, 1'b0,
                 17'd0, 17'd65536, 17'd0, 17'd65536));
      put(sprite(REQ_ADD, 32'sd1000, -32'sd1000, 31'h10_0000, 31'h8_0000, 16'h8000, 1'b1,
                 17'd0, 17'd65536, 17'd0, 17'd65536));
      put(sprite(REQ_ADD, -32'sd77777, 32'sd88888, 31'h3_0001, 31'h5_0003, 16'hC000, 1'b0,
                 17'd12345, 17'd54321, 17'd11111, 17'd22222));
      put(sprite(REQ_ADD, 32'sh7FFF_0000, 32'sh8000_FFFF, 31'h7FFF_FFFF, 31'h0000_0001,
                 16'hFFFF, 1'b1, 17'd65536, 17'd0, 17'd65536, 17'd0));
      put(sprite(REQ_ADD, 32'sh5555_5555, 32'shAAAA_AAAA, 31'h2AAA_AAAA, 31'h5555_5555,
                 16'h0001, 1'b0, 17'h0AAAA, 17'h15555, 17'h0AAAA, 17'h15555));
      put(sprite(REQ_ADD, 32'sd0, 32'sd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 16'h2000, 1'b1,
                 17'd1, 17'd2, 17'd3, 17'd4));
      put(sprite(REQ_ADD, -32'sd1, 32'sd1, 31'h1_0001, 31'h0_FFFF, 16'h3FFF, 1'b0,
                 17'd100, 17'd200, 17'd300, 17'd400));
      put(sprite(REQ_ADD, 32'sh0123_4567, 32'shFEDC_BA98, 31'h0765_4321, 31'h0012_3456,
                 16'hA5A5, 1'b1, 17'd65535, 17'd1, 17'd65535, 17'd1));
      // Batch of one: second add overflows until the next begin
      put_limit(11'd1);
      put(sprite(REQ_BEGIN, 32'sd0, 32'sd0, '0, '0, '0, 1'b0, '0, '0, '0, '0));
      put(sprite(REQ_ADD, 32'sd4096, 32'sd8192, 31'h4_0000, 31'h2_0000, 16'h6000, 1'b0,
                 17'd0, 17'd65536, 17'd0, 17'd65536));
      put_ovf(sprite(REQ_ADD, 32'sd4096, 32'sd8192, 31'h4_0000, 31'h2_0000, 16'h6000, 1'b1,
                     17'd0, 17'd65536, 17'd0, 17'd65536));
      put(sprite(REQ_BEGIN, 32'sd0, 32'sd0, '0, '0, '0, 1'b0, '0, '0, '0, '0));
      put(sprite(REQ_ADD, -32'sd4096, 32'sd0, 31'h1_0000, 31'h1_0000, 16'hE000, 1'b1,
                 17'd7, 17'd8, 17'd9, 17'd10));
      // Limit zero rejects every add
      put_limit(11'd0);
      put_ovf(sprite(REQ_ADD, 32'sd1, 32'sd2, 31'd3, 31'd4, 16'd5, 1'b0,
                     17'd6, 17'd7, 17'd8, 17'd9));
      // Largest register value, capped by the block
      put_limit(11'd2047);
      put(sprite(REQ_BEGIN, 32'sd0, 32'sd0, '0, '0, '0, 1'b0, '0, '0, '0, '0));

      // Hold reset, then release it at a falling edge
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_cfg) begin
            write_limit(plan[i].limit);
         end else begin
            send_row(plan[i]);
         end
      end

      // Random phases: each opens with a begin, then mostly adds with an occasional begin
      for (int p = 0; p < 8; p++) begin
         write_limit((p == 6) ? CNT_W'($urandom_range(1, 2047)) : phase_limit[p]);
         if (p == 7) begin
            calm = 1'b1;
         end
         for (int i = 0; i < ((p == 2) ? 20 : 66); i++) begin
            row     = '0;
            row.req = random_request((i == 0 || $urandom_range(0, 9) == 0) ? REQ_BEGIN
                                                                          : REQ_ADD);
            send_row(row);
         end
      end

      // Drain, then leave room for any stray result
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_vertices.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (error_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

   // Watchdog: stops a run that overruns its time budget and reports errors
   initial begin : watchdog
      #2_000_000;
      $display("testbench: errors");
      $finish;
   end

endmodule
